>>> sv/swm_pkg.sv
package swm_pkg;

  // Defaults for the top-level parameters
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Window size register
  localparam int             CFG_BITS     = 7;
  localparam logic [6:0]     WINDOW_RESET = 7'd3;

  // Control word from the sequencer to every cell of the row
  typedef struct packed {
    logic shift;      // push a new sample into the history row
    logic load;       // copy history into the probe row, clear rank counters
    logic count;      // advance the probe row, accumulate ranks
    logic sel_load;   // copy history into the probe row, mark the median cell
    logic sel_shift;  // advance the probe row together with the marks
  } swm_ctl_t;

endpackage

>>> sv/swm_cell.sv
module swm_cell #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int CW = $clog2(WINDOW_MAX + 1)
) (
  input  logic                          clk,
  input  swm_pkg::swm_ctl_t             ctl_i,
  input  logic        [AW-1:0]          age_i,
  input  logic        [CW-1:0]          k_i,
  input  logic        [AW-1:0]          m_i,
  input  logic signed [SAMPLE_BITS-1:0] hist_prev_i,
  output logic signed [SAMPLE_BITS-1:0] hist_o,
  input  logic signed [SAMPLE_BITS-1:0] probe_next_i,
  output logic signed [SAMPLE_BITS-1:0] probe_o,
  input  logic                          hit_next_i,
  output logic                          hit_o,
  input  logic signed [SAMPLE_BITS-1:0] probe_val_i,
  input  logic        [AW-1:0]          probe_age_i
);

  logic signed [SAMPLE_BITS-1:0] hist_r;
  logic signed [SAMPLE_BITS-1:0] probe_r;
  logic                          hit_r;
  logic        [AW-1:0]          cnt_r;
  logic                          below;
  logic                          in_win;

  // Probe ranks below this cell: smaller, or equal and older
  assign below  = (probe_val_i < hist_r) ||
                  ((probe_val_i == hist_r) && (probe_age_i > age_i));
  assign in_win = CW'(age_i) < k_i;

  // Hold history, probe, rank and mark
  always_ff @(posedge clk) begin
    if (ctl_i.shift) begin
      hist_r <= hist_prev_i;
    end
    if (ctl_i.load) begin
      probe_r <= hist_r;
      cnt_r   <= '0;
    end else if (ctl_i.count) begin
      probe_r <= probe_next_i;
      if (below) begin
        cnt_r <= cnt_r + AW'(1);
      end
    end else if (ctl_i.sel_load) begin
      probe_r <= hist_r;
      hit_r   <= in_win && (cnt_r == m_i);
    end else if (ctl_i.sel_shift) begin
      probe_r <= probe_next_i;
      hit_r   <= hit_next_i;
    end
  end

  assign hist_o  = hist_r;
  assign probe_o = probe_r;
  assign hit_o   = hit_r;

endmodule

>>> sv/sliding_window_median_core.sv
// Running median filter over the last k samples, k = cfg_window_size clamped
// to 1..WINDOW_MAX (0 acts as 1). Samples sit in a row of cells that shifts by
// one per input beat. Once k samples have arrived since reset, every input
// beat yields one output beat: the lower median, the sample of rank (k-1)/2
// in ascending order. Earlier beats yield nothing. A beat that yields a
// result occupies the block while the window samples are walked one per
// cycle past all cells, each cell counting how many rank below it, and then
// the marked median cell is shifted to the head of the row. The finished
// result waits in an output register, so computing the next result overlaps
// a stalled output.
// Write cfg_window_size only while the block is idle; no clearing after reset.
module sliding_window_median_core #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_median,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swm_pkg::CFG_BITS-1:0]  cfg_window_size
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int WW = (CW > swm_pkg::CFG_BITS) ? CW : swm_pkg::CFG_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COUNT,
    ST_SLOAD,
    ST_SEEK
  } state_t;

  state_t                         state_r, state_nxt;
  logic [swm_pkg::CFG_BITS-1:0]   wsize_r, wsize_nxt;
  logic [CW-1:0]                  fill_r, fill_nxt;
  logic [AW-1:0]                  step_r, step_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0]  out_median_r, out_median_nxt;

  swm_pkg::swm_ctl_t              ctl;
  logic [CW-1:0]                  k_w;
  logic [CW-1:0]                  km1_w;
  logic [AW-1:0]                  m_w;
  logic                           in_acc;
  logic                           out_free;

  logic signed [SAMPLE_BITS-1:0]  hist_w  [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0]  probe_w [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]          hit_w;

  // Clamp the window size and derive the median rank
  always_comb begin
    if (wsize_r == '0) begin
      k_w = CW'(1);
    end else if (WW'(wsize_r) > WW'(WINDOW_MAX)) begin
      k_w = CW'(WINDOW_MAX);
    end else begin
      k_w = CW'(wsize_r);
    end
    km1_w = k_w - CW'(1);
    m_w   = AW'(km1_w >> 1);
  end

  // Row of cells: history shifts up from cell 0, probe and marks shift down
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] hist_prev;
    logic signed [SAMPLE_BITS-1:0] probe_next;
    logic                          hit_next;

    if (i == 0) begin : g_head
      assign hist_prev = in_sample;
    end else begin : g_body
      assign hist_prev = hist_w[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_tail
      assign probe_next = probe_w[i];
      assign hit_next   = 1'b0;
    end else begin : g_link
      assign probe_next = probe_w[i+1];
      assign hit_next   = hit_w[i+1];
    end

    swm_cell #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk          (clk),
      .ctl_i        (ctl),
      .age_i        (AW'(i)),
      .k_i          (k_w),
      .m_i          (m_w),
      .hist_prev_i  (hist_prev),
      .hist_o       (hist_w[i]),
      .probe_next_i (probe_next),
      .probe_o      (probe_w[i]),
      .hit_next_i   (hit_next),
      .hit_o        (hit_w[i]),
      .probe_val_i  (probe_w[0]),
      .probe_age_i  (step_r)
    );
  end

  // Handshakes
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    wsize_nxt      = wsize_r;
    fill_nxt       = fill_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r;
    out_median_nxt = out_median_r;
    ctl            = '0;

    if (cfg_valid && cfg_ready) begin
      wsize_nxt = cfg_window_size;
    end

    // drop the output beat once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ctl.shift = 1'b1;
          if (fill_r != CW'(WINDOW_MAX)) begin
            fill_nxt = fill_r + CW'(1);
          end
          if (fill_nxt >= k_w) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        ctl.load  = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        ctl.count = 1'b1;
        if (CW'(step_r) == km1_w) begin
          state_nxt = ST_SLOAD;
        end else begin
          step_nxt = step_r + AW'(1);
        end
      end
      ST_SLOAD: begin
        ctl.sel_load = 1'b1;
        state_nxt    = ST_SEEK;
      end
      ST_SEEK: begin
        if (hit_w[0]) begin
          // hold the median at the head until the output register frees up
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_median_nxt = probe_w[0];
            state_nxt      = ST_IDLE;
          end
        end else begin
          ctl.sel_shift = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wsize_r     <= swm_pkg::WINDOW_RESET;
      fill_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wsize_r     <= wsize_nxt;
      fill_r      <= fill_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_median_r <= out_median_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

`ifndef SYNTHESIS
  // A result appears only when the seek finds the median cell
  a_out_from_seek: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_SEEK))
    else $error("output beat raised outside the seek phase");

  // Exactly one cell carries the median mark during the seek
  a_one_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEEK) |-> $onehot(hit_w))
    else $error("median mark is not unique");

  // The rank count runs straight into the mark load
  a_count_then_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SLOAD) |-> ($past(state_r) == ST_COUNT))
    else $error("mark load not preceded by the rank count");

  // Work starts only on a full window
  a_full_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (fill_r >= k_w))
    else $error("median started before the window filled");
`endif

endmodule

>>> verif/tb_sliding_window_median_core.sv
`timescale 1ns / 100ps

module tb_sliding_window_median_core;

  localparam int SB            = swm_pkg::SAMPLE_BITS_DEF;
  localparam int WMAX          = swm_pkg::WINDOW_MAX_DEF;
  localparam int SETTLE_CYCLES = 2 * WMAX + 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 108;
  localparam int STALL_LIMIT   = 5000;

  typedef enum int {
    IDLE_SENDER_LIGHT,
    IDLE_SENDER_HEAVY,
    IDLE_NONE
  } idle_mode_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic signed [SB-1:0] in_sample       = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic signed [SB-1:0] out_median;
  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic [swm_pkg::CFG_BITS-1:0] cfg_window_size = '0;

  // Shadow of the filter state
  int                           hist [WMAX];
  int                           wr_ptr  = 0;
  int                           fill    = 0;
  logic [swm_pkg::CFG_BITS-1:0] win_reg = swm_pkg::WINDOW_RESET;

  logic signed [SB-1:0] median_q [$];
  int                   err_count     = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   hold_reqs     = 0;
  int                   hold_done     = 0;
  int                   hold_left     = 0;
  int                   quiet_cycles  = 0;

  sliding_window_median_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_median      (out_median),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_window_size (cfg_window_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Push one sample into the shadow ring and queue the lower median if due
  function automatic void predict_median(input logic signed [SB-1:0] value);
    int k;
    int v;
    int i;
    int win [WMAX];
    k = (win_reg == 0) ? 1 : ((win_reg > WMAX) ? WMAX : int'(win_reg));
    hist[wr_ptr] = int'(value);
    wr_ptr = (wr_ptr + 1) % WMAX;
    if (fill < WMAX) fill++;
    if (fill < k) return;
    // insertion sort of the last k samples, newest first
    for (int a = 0; a < k; a++) begin
      v = hist[(wr_ptr + WMAX - 1 - a) % WMAX];
      i = a;
      while (i > 0 && win[i-1] > v) begin
        win[i] = win[i-1];
        i--;
      end
      win[i] = v;
    end
    median_q.push_back(SB'(win[(k - 1) / 2]));
  endfunction

  function automatic logic signed [SB-1:0] random_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return SB'($urandom);
    if (sel <= 7) return SB'(int'($urandom_range(0, 6)) - 3);
    if (sel == 8) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return SB'(int'($urandom_range(0, 200)) - 100 + 16'sh1000);
  endfunction

  function automatic logic [swm_pkg::CFG_BITS-1:0] phase_window(input int idx);
    case (idx)
      0:       return 7'd1;
      1:       return 7'd64;
      2:       return 7'd5;
      3:       return 7'd127;
      4:       return 7'd2;
      5:       return 7'd0;
      6:       return 7'd17;
      7:       return 7'd65;
      8:       return 7'd4;
      9:       return 7'($urandom_range(1, 16));
      10:      return 7'd64;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic void set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        send_idle_pct = 7;
        recv_idle_pct = 86;
      end
      IDLE_SENDER_HEAVY: begin
        send_idle_pct = 86;
        recv_idle_pct = 7;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  // Offer one sample beat, hold it until taken, then predict
  task automatic send_sample(input logic signed [SB-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (in_stall);
    predict_median(value);
  endtask

  // Stop offering, wait for every expected median, then let the core settle
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_size(input logic [swm_pkg::CFG_BITS-1:0] value);
    wait_for_drain();
    cfg_valid       <= 1'b1;
    cfg_window_size <= value;
    do @(posedge clk); while (!cfg_ready);
    win_reg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_sample_extremes();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
  endtask

  task automatic test_equal_samples();
    send_sample(16'sd5);
    send_sample(16'sd5);
    send_sample(16'sd5);
    send_sample(-16'sd7);
    send_sample(-16'sd7);
  endtask

  // Grow the window past the fill level, then drop to zero which acts as one
  task automatic test_window_change();
    write_window_size(7'd64);
    repeat (4) send_sample(random_sample());
    write_window_size(7'd0);
    repeat (3) send_sample(random_sample());
  endtask

  task automatic test_even_window();
    write_window_size(7'd2);
    send_sample(16'sd100);
    send_sample(-16'sd100);
    send_sample(16'sd3);
  endtask

  task automatic test_random_phases();
    for (int m = 0; m < 3; m++) begin
      set_idling(idle_mode_t'(m));
      for (int p = 0; p < 4; p++) begin
        write_window_size(phase_window(m * 4 + p));
        repeat (PHASE_ITEMS) send_sample(random_sample());
      end
    end
  endtask

  // Hold the output long enough to back up the core, then pause for a drain
  task automatic test_output_backpressure();
    set_idling(IDLE_NONE);
    write_window_size(7'd8);
    hold_reqs++;
    repeat (30) send_sample(random_sample());
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (10) send_sample(random_sample());
  endtask

  // Drive the result stall: long hold-off on request, else random idling
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_done != hold_reqs) begin
      hold_done = hold_reqs;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Check each median beat against the oldest expectation
  always @(posedge clk) begin
    logic signed [SB-1:0] exp_median;
    if (rst_n && out_valid && !out_stall) begin
      if (median_q.size() == 0) begin
        $error("median: unexpected beat, got %0d", out_median);
        err_count++;
      end else begin
        exp_median = median_q.pop_front();
        if (out_median !== exp_median) begin
          $error("median mismatch: expected %0d, got %0d", exp_median, out_median);
          err_count++;
        end
      end
    end
  end

  // End the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sample_extremes();
    test_equal_samples();
    test_window_change();
    test_even_window();
    test_random_phases();
    test_output_backpressure();
    wait_for_drain();
    if (err_count == 0 && median_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
